// ----- src/edm_pkg.sv -----
`default_nettype none

package edm_pkg;

  localparam int GAIN_BITS      = 16;
  localparam int MIX_BITS       = 17;
  localparam int CFG_DATA_BITS  = 17;
  localparam int CFG_INDEX_BITS = 1;
  localparam int ENTRY_BITS     = 31;
  localparam int FRAC_OUT_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_DRIVE_GAIN = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WET_MIX    = 1'b1;

  localparam logic [GAIN_BITS-1:0]  GAIN_RESET = 16'd4096;
  localparam logic [MIX_BITS-1:0]   MIX_RESET  = 17'd0;
  localparam logic [MIX_BITS-1:0]   MIX_ONE    = 17'd65536;
  localparam logic [15:0]           GAIN_ROUND = 16'd2048;
  localparam logic [15:0]           MIX_ROUND  = 16'd32768;
  localparam logic [ENTRY_BITS-1:0] ONE_Q30    = 31'h4000_0000;

  typedef struct packed {
    logic [GAIN_BITS-1:0] gain;
    logic [MIX_BITS-1:0]  mix;
  } cfg_t;

  function automatic logic [63:0] taylor_div(input logic [63:0] v, input int k);
    case (k)
      1:  return v;       2:  return v / 2;   3:  return v / 3;   4:  return v / 4;
      5:  return v / 5;   6:  return v / 6;   7:  return v / 7;   8:  return v / 8;
      9:  return v / 9;   10: return v / 10;  11: return v / 11;  12: return v / 12;
      13: return v / 13;  14: return v / 14;  15: return v / 15;  16: return v / 16;
      17: return v / 17;  18: return v / 18;  19: return v / 19;  20: return v / 20;
      21: return v / 21;  22: return v / 22;  23: return v / 23;  24: return v / 24;
      default: return v;
    endcase
  endfunction

  function automatic logic [63:0] exp_ratio(input logic [63:0] h);
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] negs;
    logic [63:0] r;
    term = 64'd1 << 30;
    pos  = 64'd1 << 30;
    negs = 64'd0;
    for (int k = 1; k <= 24; k++) begin
      term = taylor_div((term * h) >> 30, k);
      if (k % 2 == 1) begin
        negs = negs + term;
      end else begin
        pos = pos + term;
      end
    end
    r = (pos > negs) ? pos - negs : 64'd0;
    if (r >= (64'd1 << 30)) begin
      r = (64'd1 << 30) - 64'd1;
    end
    return r;
  endfunction

  function automatic logic [63:0] exp_entry(input int k, input logic [63:0] r);
    logic [63:0] e;
    e = 64'd1 << 30;
    for (int j = 1; j <= k; j++) begin
      e = (e * r + (64'd1 << 29)) >> 30;
    end
    return e;
  endfunction

  function automatic logic [63:0] out_limit(input int f);
    return (64'd999 << f) / 1000;
  endfunction

endpackage

`default_nettype wire

// ----- src/edm_front.sv -----
`default_nettype none

module edm_front #(
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire edm_pkg::cfg_t                 cfg,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               neg,
  output logic [SAMPLE_BITS+3:0]             qmag
);
  import edm_pkg::*;

  localparam int S  = SAMPLE_BITS;
  localparam int PW = S + GAIN_BITS;

  logic         v1;
  logic         neg1;
  logic [S-1:0] mag1;
  logic [S-1:0] x_u;
  logic [S-1:0] mag_next;
  logic         rdy2;
  logic [PW-1:0] qsum;

  assign x_u      = sample_in;
  assign mag_next = x_u[S-1] ? (~x_u + S'(1)) : x_u;
  assign rdy2     = !out_valid || out_ready;
  assign in_ready = !v1 || rdy2;
  assign qsum     = PW'(mag1) * PW'(cfg.gain) + PW'(GAIN_ROUND);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_ready) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      neg1 <= x_u[S-1];
      mag1 <= mag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy2) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      neg  <= neg1;
      qmag <= qsum[PW-1:12];
    end
  end

endmodule

`default_nettype wire

// ----- src/edm_shaper.sv -----
`default_nettype none

module edm_shaper #(
  parameter int SAMPLE_BITS       = 24,
  parameter int EXP_TABLE_ENTRIES = 256
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   neg_in,
  input  wire logic [SAMPLE_BITS+3:0] qmag_in,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        neg,
  output logic [SAMPLE_BITS+3:0]      qmag,
  output logic [SAMPLE_BITS-1:0]      shaped
);
  import edm_pkg::*;

  localparam int S  = SAMPLE_BITS;
  localparam int F  = S - 1;
  localparam int N  = EXP_TABLE_ENTRIES;
  localparam int NB = $clog2(N + 1);
  localparam int QW = S + 4;
  localparam int PW = QW + NB;
  localparam int DW = ENTRY_BITS + FRAC_OUT_BITS;
  localparam logic [63:0] H = ((64'd1 << 34) + 64'(N / 2)) / N;
  localparam logic [63:0] R = exp_ratio(H);

  logic [ENTRY_BITS-1:0] rom_a [0:N];
  logic [ENTRY_BITS-1:0] rom_d [0:N];

  for (genvar k = 0; k <= N; k++) begin : g_rom
    localparam logic [63:0] A = exp_entry(k, R);
    localparam logic [63:0] B = (k < N) ? exp_entry(k + 1, R) : A;
    assign rom_a[k] = A[ENTRY_BITS-1:0];
    assign rom_d[k] = (A > B) ? ENTRY_BITS'(A - B) : '0;
  end

  logic                     v3;
  logic                     neg3;
  logic [QW-1:0]            qmag3;
  logic [ENTRY_BITS-1:0]    a3;
  logic [ENTRY_BITS-1:0]    d3;
  logic [FRAC_OUT_BITS-1:0] frac3;
  logic [ENTRY_BITS-1:0]    e4;
  logic                     rdy4;
  logic [PW-1:0]            posn;
  logic [NB:0]              idx_full;
  logic [NB-1:0]            idx;
  logic [DW-1:0]            dp;
  logic [ENTRY_BITS-1:0]    s30;

  assign posn     = PW'(qmag_in) * PW'(N);
  assign idx_full = posn[PW-1:F+4];
  assign idx      = (idx_full >= (NB+1)'(N)) ? NB'(N) : idx_full[NB-1:0];
  assign rdy4     = !out_valid || out_ready;
  assign in_ready = !v3 || rdy4;
  assign dp       = DW'(d3) * DW'(frac3);
  assign s30      = ONE_Q30 - e4;

  localparam int SH = 30 - F;
  if (SH > 0) begin : g_round
    logic [ENTRY_BITS:0] s_sum;
    assign s_sum  = {1'b0, s30} + ((ENTRY_BITS+1)'(1) << (SH - 1));
    assign shaped = s_sum[SH+S-1:SH];
  end else begin : g_widen
    assign shaped = S'(s30) << (F - 30);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (in_ready) begin
      v3 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      neg3  <= neg_in;
      qmag3 <= qmag_in;
      a3    <= rom_a[idx];
      d3    <= rom_d[idx];
      frac3 <= posn[F+3:F-12];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy4) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      neg  <= neg3;
      qmag <= qmag3;
      e4   <= a3 - dp[DW-1:FRAC_OUT_BITS];
    end
  end

endmodule

`default_nettype wire

// ----- src/edm_blend.sv -----
`default_nettype none

module edm_blend #(
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire edm_pkg::cfg_t          cfg,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   neg_in,
  input  wire logic [SAMPLE_BITS+3:0] qmag_in,
  input  wire logic [SAMPLE_BITS-1:0] shaped_in,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic signed [SAMPLE_BITS-1:0] sample_out
);
  import edm_pkg::*;

  localparam int S  = SAMPLE_BITS;
  localparam int WW = S + MIX_BITS;
  localparam int YW = S + 4 + MIX_BITS;
  localparam int SW = YW + 1;
  localparam int MW = SW - 16;
  localparam logic [S-1:0] LIMIT = S'(out_limit(S - 1));

  logic          v5;
  logic          neg5;
  logic [WW-1:0] wet5;
  logic [YW-1:0] dry5;
  logic          rdy6;
  logic [SW-1:0] sum;
  logic [MW-1:0] m;
  logic [S-1:0]  m_cl;

  assign rdy6     = !out_valid || out_ready;
  assign in_ready = !v5 || rdy6;
  assign sum      = SW'(wet5) + SW'(dry5) + SW'(MIX_ROUND);
  assign m        = sum[SW-1:16];
  assign m_cl     = (m > MW'(LIMIT)) ? LIMIT : m[S-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (in_ready) begin
      v5 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      neg5 <= neg_in;
      wet5 <= WW'(cfg.mix) * WW'(shaped_in);
      dry5 <= YW'(MIX_ONE - cfg.mix) * YW'(qmag_in);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy6) begin
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy6) begin
      sample_out <= neg5 ? $signed(~m_cl + S'(1)) : $signed(m_cl);
    end
  end

endmodule

`default_nettype wire

// ----- src/exponential_distortion_mix_unit.sv -----
// Exponential waveshaping distortion with a dry/wet blend, one sample per transfer.
// Input channel: in_valid, in_ready and sample_in, a signed Q1.(SAMPLE_BITS-1) sample.
// Output channel: out_valid, out_ready and sample_out, in the same format, clamped
// to plus or minus 0.999 of full scale.
// Configuration: a write with cfg_write high stores cfg_data into register cfg_index:
// index 0 is drive_gain (unsigned Q4.12), index 1 is wet_mix (Q1.16, values above
// unity act as unity). Write only while no sample is in flight.
// Pipeline: six pipeline registers, two in each of edm_front, edm_shaper and edm_blend.
// Throughput: one sample per cycle while out_ready stays high; the table read and the
// multipliers are spread over the pipeline stages.
// Every stage holds its sample while the next stage is full and stalled, so a stall
// of the receiver fills the pipeline before in_ready falls; nothing is lost.
// Reset clears the pipeline and sets drive_gain to unity and wet_mix to zero.
`default_nettype none

module exponential_distortion_mix_unit #(
  parameter int SAMPLE_BITS       = 24,
  parameter int EXP_TABLE_ENTRIES = 256
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_write,
  input  wire logic [edm_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire logic [edm_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0]         sample_in,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [SAMPLE_BITS-1:0]              sample_out
);
  import edm_pkg::*;

  localparam int S = SAMPLE_BITS;
  localparam logic [S-1:0] LIMIT = S'(out_limit(S - 1));

  logic [GAIN_BITS-1:0] drive_gain;
  logic [MIX_BITS-1:0]  wet_mix;
  cfg_t                 cfg;

  logic         f_valid;
  logic         f_ready;
  logic         f_neg;
  logic [S+3:0] f_qmag;
  logic         s_valid;
  logic         s_ready;
  logic         s_neg;
  logic [S+3:0] s_qmag;
  logic [S-1:0] s_shaped;

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_gain <= GAIN_RESET;
      wet_mix    <= MIX_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DRIVE_GAIN: drive_gain <= cfg_data[GAIN_BITS-1:0];
        REG_WET_MIX:    wet_mix    <= cfg_data[MIX_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.gain = drive_gain;
  assign cfg.mix  = (wet_mix > MIX_ONE) ? MIX_ONE : wet_mix;

  edm_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample_in (sample_in),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .neg       (f_neg),
    .qmag      (f_qmag)
  );

  edm_shaper #(
    .SAMPLE_BITS       (SAMPLE_BITS),
    .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
  ) u_shaper (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .neg_in    (f_neg),
    .qmag_in   (f_qmag),
    .out_valid (s_valid),
    .out_ready (s_ready),
    .neg       (s_neg),
    .qmag      (s_qmag),
    .shaped    (s_shaped)
  );

  edm_blend #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_blend (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_valid),
    .in_ready   (s_ready),
    .neg_in     (s_neg),
    .qmag_in    (s_qmag),
    .shaped_in  (s_shaped),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out)
  );

`ifndef ASSERT_OFF
  a_out_bounded: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((sample_out[S-1] ? (~sample_out + S'(1)) : sample_out) <= LIMIT))
    else $error("sample_out beyond the clamp limit");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid straight after reset");

  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled although the receiver takes results");
`endif

endmodule

`default_nettype wire

// ----- verif/exponential_distortion_mix_checker.sv -----
`default_nettype none

module exponential_distortion_mix_checker (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [edm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [edm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic                               in_valid,
  input  wire logic                               in_ready,
  input  wire logic [23:0]                        sample_in,
  input  wire logic                               out_valid,
  input  wire logic                               out_ready,
  input  wire logic [23:0]                        sample_out,
  output int                                      outstanding,
  output int                                      mismatches
);
  timeunit 1ns;
  timeprecision 1ps;
  import edm_pkg::*;

  localparam int SAMPLE_W   = 24;
  localparam int FRAC_W     = SAMPLE_W - 1;
  localparam int ROM_POINTS = 256;
  localparam int OUT_SHIFT  = 30 - FRAC_W;
  localparam logic [63:0] UNIT_Q30  = 64'd1 << 30;
  localparam logic [63:0] OUT_LIMIT = (64'd999 << FRAC_W) / 64'd1000;

  logic [63:0]          decay_rom [0:ROM_POINTS];
  logic [GAIN_BITS-1:0] gain_now;
  logic [MIX_BITS-1:0]  mix_now;
  logic [23:0]          awaited_samples [$];
  logic [23:0]          wanted;

  initial begin
    logic [63:0] step;
    logic [63:0] term;
    logic [63:0] plus;
    logic [63:0] minus;
    logic [63:0] ratio;
    step = ((64'd1 << 34) + ROM_POINTS / 2) / ROM_POINTS;
    term = UNIT_Q30;
    plus = UNIT_Q30;
    minus = 64'd0;
    for (int k = 1; k <= 24; k++) begin
      term = ((term * step) >> 30) / k;
      if (k % 2 == 1) begin
        minus = minus + term;
      end else begin
        plus = plus + term;
      end
    end
    ratio = (plus > minus) ? plus - minus : 64'd0;
    if (ratio >= UNIT_Q30) begin
      ratio = UNIT_Q30 - 64'd1;
    end
    decay_rom[0] = UNIT_Q30;
    for (int k = 1; k <= ROM_POINTS; k++) begin
      decay_rom[k] = (decay_rom[k-1] * ratio + (64'd1 << 29)) >> 30;
    end
  end

  function automatic logic [23:0] distorted_sample(input logic [23:0] x,
                                                   input logic [GAIN_BITS-1:0] gain,
                                                   input logic [MIX_BITS-1:0] mix_reg);
    logic        negative;
    logic [63:0] mag;
    logic [63:0] qmag;
    logic [63:0] mix;
    logic [63:0] posn;
    logic [63:0] idx;
    logic [63:0] frac;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] e;
    logic [63:0] s;
    logic [63:0] m;
    negative = x[SAMPLE_W-1];
    mag = negative ? ((64'd1 << SAMPLE_W) - x) : {40'd0, x};
    mix = (mix_reg > MIX_ONE) ? {47'd0, MIX_ONE} : {47'd0, mix_reg};
    qmag = (mag * gain + GAIN_ROUND) >> 12;
    if (qmag == 64'd0) begin
      return 24'd0;
    end
    posn = qmag * ROM_POINTS;
    idx = posn >> (FRAC_W + 4);
    frac = (posn & ((64'd1 << (FRAC_W + 4)) - 64'd1)) >> (FRAC_W + 4 - 16);
    if (idx >= ROM_POINTS) begin
      e = decay_rom[ROM_POINTS];
    end else begin
      a = decay_rom[idx];
      b = decay_rom[idx + 1];
      e = a - ((((a > b) ? a - b : 64'd0) * frac) >> 16);
    end
    s = (UNIT_Q30 - e + (64'd1 << (OUT_SHIFT - 1))) >> OUT_SHIFT;
    m = (mix * s + (64'd65536 - mix) * qmag + MIX_ROUND) >> 16;
    if (m > OUT_LIMIT) begin
      m = OUT_LIMIT;
    end
    return negative ? (24'd0 - m[23:0]) : m[23:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    if (mismatches < 40) begin
      $display("%0t ns: %s: got %0d, want %0d", $time, what, $signed(got), $signed(want));
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      awaited_samples.delete();
      gain_now <= GAIN_RESET;
      mix_now <= MIX_RESET;
      outstanding <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_DRIVE_GAIN: gain_now <= cfg_data[GAIN_BITS-1:0];
          REG_WET_MIX:    mix_now <= cfg_data[MIX_BITS-1:0];
          default:        ;
        endcase
      end
      if (in_valid && in_ready) begin
        awaited_samples.push_back(distorted_sample(sample_in, gain_now, mix_now));
      end
      if (out_valid && out_ready) begin
        if (awaited_samples.size() == 0) begin
          report_mismatch("output transfer with nothing awaited", sample_out, 24'd0);
        end else begin
          wanted = awaited_samples.pop_front();
          if (sample_out !== wanted) begin
            report_mismatch("sample_out", sample_out, wanted);
          end
        end
      end
      outstanding <= awaited_samples.size();
    end
  end

endmodule

`default_nettype wire

// ----- verif/exponential_distortion_mix_unit_test.sv -----
`default_nettype none

module exponential_distortion_mix_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import edm_pkg::*;

  typedef enum logic [1:0] {FLOW_FREE, SENDER_IDLE, RECEIVER_STALL, BOTH_IDLE} traffic_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_DRIVE_GAIN;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [23:0]               sample_in = 24'd0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [23:0]               sample_out;
  int                        outstanding;
  int                        mismatches;
  traffic_t                  traffic = FLOW_FREE;
  logic                      long_hold = 1'b0;

  always #5ns clk = ~clk;

  exponential_distortion_mix_unit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out)
  );

  exponential_distortion_mix_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample_in   (sample_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sample_out  (sample_out),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  task automatic send_sample(input logic [23:0] value);
    int pct;
    pct = (traffic == SENDER_IDLE) ? 53 : (traffic == BOTH_IDLE) ? 21 : 0;
    if ($urandom_range(99) < pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_in <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(input logic [GAIN_BITS-1:0] gain, input logic [MIX_BITS-1:0] mix);
    wait_until_drained();
    cfg_write <= 1'b1;
    cfg_index <= REG_DRIVE_GAIN;
    cfg_data <= {1'b0, gain};
    @(posedge clk);
    cfg_index <= REG_WET_MIX;
    cfg_data <= mix;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [23:0] random_sample();
    logic [23:0] v;
    case ($urandom_range(9))
      6, 7: v = 24'($urandom_range(8191));
      8: return $urandom_range(1) ? 24'h800000 : 24'h7FFFFF;
      9: v = 24'($urandom_range(1 << 20));
      default: return 24'($urandom);
    endcase
    return $urandom_range(1) ? 24'd0 - v : v;
  endfunction

  initial begin : drain
    int hold_left;
    bit hold_done;
    int stall_pct;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 64;
      end
      stall_pct = (traffic == RECEIVER_STALL) ? 53 : (traffic == BOTH_IDLE) ? 21 : 0;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    #2ms;
    $display("exponential_distortion_mix_unit_test: done, errors");
    $finish;
  end

  initial begin
    logic [GAIN_BITS-1:0] gain;
    logic [MIX_BITS-1:0]  mix;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Settings as left by reset: unity gain, dry only. Full scale clamps both ways.
    send_sample(24'd0);
    send_sample(24'd1);
    send_sample(24'hFFFFFF);
    send_sample(24'h7FFFFF);
    send_sample(24'h800000);
    send_sample(24'h400000);
    send_sample(24'hC00000);

    // Largest gain and a mix above unity, which must act as fully shaped.
    configure(16'hFFFF, 17'h1FFFF);
    send_sample(24'h7FFFFF);
    send_sample(24'h800000);
    send_sample(24'd1);
    send_sample(24'hFFFFFF);
    send_sample(24'h000100);
    send_sample(24'hFFFF00);
    send_sample(24'h123456);

    // The smallest gain rounds small inputs to a zero product.
    configure(16'd1, MIX_ONE);
    send_sample(24'd2047);
    send_sample(24'd0 - 24'd2047);
    send_sample(24'd2048);
    send_sample(24'h7FFFFF);
    send_sample(24'h800000);

    configure(16'd0, 17'd32768);
    send_sample(24'h555555);
    send_sample(24'hAAAAAA);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin gain = GAIN_RESET; mix = MIX_ONE; end
        1: begin gain = 16'hFFFF; mix = MIX_RESET; end
        2: begin gain = 16'd0; mix = 17'h1FFFF; end
        3: begin gain = 16'($urandom); mix = 17'($urandom_range(65536)); end
        4: begin gain = 16'($urandom); mix = 17'($urandom_range(131071, 65537)); end
        5: begin gain = 16'($urandom_range(8191)); mix = 17'($urandom_range(65536)); end
        6: begin gain = 16'd8192; mix = 17'd32768; end
        default: begin gain = 16'($urandom); mix = 17'($urandom); end
      endcase
      configure(gain, mix);
      traffic <= traffic_t'(p % 4);
      if (p == 0) begin
        long_hold <= 1'b1;
      end
      repeat (116) send_sample(random_sample());
    end

    wait_until_drained();
    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("exponential_distortion_mix_unit_test: done, clean");
    end else begin
      $display("exponential_distortion_mix_unit_test: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- exponential_distortion_mix_unit.f -----
src/edm_pkg.sv
src/edm_front.sv
src/edm_shaper.sv
src/edm_blend.sv
src/exponential_distortion_mix_unit.sv
verif/exponential_distortion_mix_checker.sv
verif/exponential_distortion_mix_unit_test.sv
